[rtl/srblit_pkg.sv]
// ----------------------------------------------------------------------------
// srblit_pkg
// Shared types and constants for the 1bpp sprite row blitter.
// ----------------------------------------------------------------------------
package srblit_pkg;

  localparam int LINE_PIXELS = 200;
  localparam int LINE_COUNT  = 150;
  localparam int LINE_BYTES  = LINE_PIXELS >> 3;
  localparam int STORE_BYTES = LINE_COUNT * LINE_BYTES;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int COL_W  = 8;
  localparam int ROW_W  = 11;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW0,
    S_DRAW1,
    S_DRAW2,
    S_READ0,
    S_READ1,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    STEP_FIRST,
    STEP_MID,
    STEP_THIRD
  } step_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       clipped;
  } res_t;

endpackage

[rtl/srblit_merge.sv]
// ----------------------------------------------------------------------------
// srblit_merge
// Shared shift and merge unit: aligns the sprite row to the pixel column and
// merges one byte of it into the old stored byte under the matching mask.
// ----------------------------------------------------------------------------
module srblit_merge (
  input  srblit_pkg::step_t step,
  input  logic [15:0]       sprite_row,
  input  logic [2:0]        shift,
  input  logic [7:0]        old_byte,
  output logic [7:0]        new_byte
);
  import srblit_pkg::*;

  logic [23:0] bits_wide;
  logic [23:0] mask_wide;
  logic [7:0]  bits;
  logic [7:0]  mask;

  assign bits_wide = {sprite_row, 8'h00} >> shift;
  assign mask_wide = 24'hffff00 >> shift;

  always_comb begin
    case (step)
      STEP_FIRST: begin
        bits = bits_wide[23:16];
        mask = mask_wide[23:16];
      end
      STEP_MID: begin
        bits = bits_wide[15:8];
        mask = mask_wide[15:8];
      end
      STEP_THIRD: begin
        bits = bits_wide[7:0];
        mask = mask_wide[7:0];
      end
      default: begin
        bits = 8'h00;
        mask = 8'h00;
      end
    endcase
  end

  assign new_byte = (old_byte & ~mask) | (bits & mask);

endmodule

[rtl/srblit_core.sv]
// ----------------------------------------------------------------------------
// srblit_core
// Sequencer and frame store: runs the byte read-modify-writes of a draw, the
// read, and the clearing sweep, and holds one result until it is taken.
// ----------------------------------------------------------------------------
module srblit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [15:0]       sprite_row,
  input  logic [7:0]        pixel_x,
  input  logic [7:0]        line,
  input  logic [4:0]        byte_column,
  output logic              res_valid,
  input  logic              res_ready,
  output srblit_pkg::res_t  res
);
  import srblit_pkg::*;

  localparam logic [COL_W-1:0]  LINE_BYTES_C = COL_W'(LINE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STORE_BYTES - 1);

  state_t state;
  state_t state_next;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  logic [15:0]       sprite;
  logic [2:0]        shift;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] base;
  logic              read_ok;
  logic              clip;
  logic [7:0]        rbyte;
  logic              clr_op;
  logic [ADDR_W-1:0] clr_addr;

  logic              row_in_ok;
  logic              bcol_in_ok;
  logic [COL_W-1:0]  col_mid;
  logic [COL_W-1:0]  col_third;
  logic              first_ok;
  logic              mid_ok;
  logic              third_ok;

  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              clip_set;
  step_t             step;
  logic [7:0]        merged;

  assign row_in_ok  = ROW_W'(line) < ROW_W'(LINE_COUNT);
  assign bcol_in_ok = COL_W'(byte_column) < LINE_BYTES_C;
  assign col_mid    = col + COL_W'(1);
  assign col_third  = col + COL_W'(2);
  assign first_ok   = col < LINE_BYTES_C;
  assign mid_ok     = col_mid < LINE_BYTES_C;
  assign third_ok   = col_third < LINE_BYTES_C;

  srblit_merge u_merge (
    .step       (step),
    .sprite_row (sprite),
    .shift      (shift),
    .old_byte   (rdata),
    .new_byte   (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    raddr      = base + ADDR_W'(col);
    we         = 1'b0;
    waddr      = base + ADDR_W'(col);
    wdata      = merged;
    clip_set   = 1'b0;
    step       = STEP_MID;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_DRAW:  state_next = row_in_ok ? S_DRAW0 : S_DONE;
            OP_READ:  state_next = S_READ0;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_DRAW0: begin
        rd_en      = first_ok;
        we         = mid_ok;
        waddr      = base + ADDR_W'(col_mid);
        step       = STEP_MID;
        clip_set   = !mid_ok;
        state_next = S_DRAW1;
      end
      S_DRAW1: begin
        we         = first_ok;
        step       = STEP_FIRST;
        clip_set   = !first_ok;
        rd_en      = (shift != 3'd0) && third_ok;
        raddr      = base + ADDR_W'(col_third);
        state_next = (shift != 3'd0) ? S_DRAW2 : S_DONE;
      end
      S_DRAW2: begin
        we         = third_ok;
        waddr      = base + ADDR_W'(col_third);
        step       = STEP_THIRD;
        clip_set   = !third_ok;
        state_next = S_DONE;
      end
      S_READ0: begin
        rd_en      = read_ok;
        state_next = S_READ1;
      end
      S_READ1: begin
        state_next = S_DONE;
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = 8'h00;
        if (clr_addr == LAST_ADDR) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_op   <= 1'b0;
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + ADDR_W'(1);
    end else if (state == S_IDLE && in_valid) begin
      clr_op <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      sprite <= sprite_row;
      shift  <= pixel_x[2:0];
      if (opcode == OP_READ) begin
        col <= COL_W'(byte_column);
      end else begin
        col <= COL_W'(pixel_x >> 3);
      end
      base    <= ADDR_W'(line * LINE_BYTES);
      read_ok <= row_in_ok && bcol_in_ok;
      rbyte   <= 8'h00;
      clip    <= ((opcode == OP_DRAW) && !row_in_ok) ||
                 ((opcode == OP_READ) && !(row_in_ok && bcol_in_ok));
    end else begin
      if (clip_set) begin
        clip <= 1'b1;
      end
      if (state == S_READ1) begin
        rbyte <= read_ok ? rdata : 8'h00;
      end
    end
  end

  assign res.read_byte = rbyte;
  assign res.clipped   = clip;

  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && we |-> raddr != waddr)
    else $error("Read and write hit the same frame store byte.");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> we && wdata == 8'h00)
    else $error("Clearing sweep did not write zero.");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready && state == S_CLEAR)
    else $error("Block took a word before the clearing pass.");

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_DRAW && row_in_ok |=> state == S_DRAW0)
    else $error("Draw on a valid line did not start its byte sequence.");

endmodule

[rtl/sprite_row_blitter_1bpp.sv]
// ----------------------------------------------------------------------------
// sprite_row_blitter_1bpp
// 1bpp frame store with masked sprite row draw, byte read and whole clear.
// ----------------------------------------------------------------------------
// The store holds 150 lines of 25 bytes, eight pixels to a byte, leftmost
// pixel in the most significant bit, in one memory with a registered read
// port and a write port. Every word in gives one result word. A draw steps
// through S_DRAW0 and S_DRAW1, and also S_DRAW2 when pixel_x is not a
// multiple of eight, a sequence set by the registered memory read and the
// one write per cycle; a read steps through S_READ0 and S_READ1. A clear
// writes one byte per cycle over all 3750 bytes of the store. After reset
// the block runs the same clearing pass with in_ready low.
// The output register lets a result wait while the next word is taken.
module sprite_row_blitter_1bpp (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] sprite_row,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  line,
  input  logic [4:0]  byte_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_byte,
  output logic        clipped
);
  import srblit_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  srblit_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .sprite_row  (sprite_row),
    .pixel_x     (pixel_x),
    .line        (line),
    .byte_column (byte_column),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      read_byte <= res.read_byte;
      clipped   <= res.clipped;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 1bpp sprite row blitter.
// ----------------------------------------------------------------------------
// A directed table covers the following cases:
//   - reads at the edges of the store and outside it,
//   - draws that are aligned and not aligned,
//   - draws clipped at the line end and below the last line,
//   - the unused opcode and a clear.
// Random words follow in four idling phases. The random words are mostly draws
// and reads on a few lines, so that reads return drawn data. Each accepted word
// runs through a local copy of the frame store, which gives the expected read
// byte and clip flag. Result words are compared in order against those values.
// The receiver holds off for a long stretch once, so that the block backs up.
// ----------------------------------------------------------------------------
module tb;
  import srblit_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 460;
  localparam int MAX_CLEARS  = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] spr;
    logic [7:0]  x;
    logic [7:0]  row;
    logic [4:0]  bcol;
  } blit_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] spr;
    logic [7:0]  x;
    logic [7:0]  row;
    logic [4:0]  bcol;
    logic        typed;
    logic [7:0]  rd;
    logic        clip;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd0,  1'b1, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd149, 5'd24, 1'b1, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd150, 5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd25, 1'b1, 8'h00, 1'b1},
    '{OP_READ,  16'h0000, 8'd0,   8'd255, 5'd31, 1'b1, 8'h00, 1'b1},
    '{OP_DRAW,  16'hffff, 8'd0,   8'd0,   5'd0,  1'b1, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd0,  1'b1, 8'hff, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd1,  1'b1, 8'hff, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd2,  1'b1, 8'h00, 1'b0},
    '{OP_DRAW,  16'ha5c3, 8'd3,   8'd1,   5'd0,  1'b0, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd1,   5'd0,  1'b0, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd1,   5'd1,  1'b0, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd1,   5'd2,  1'b0, 8'h00, 1'b0},
    '{OP_DRAW,  16'h0f0f, 8'd184, 8'd2,   5'd0,  1'b1, 8'h00, 1'b0},
    '{OP_DRAW,  16'hf00f, 8'd185, 8'd2,   5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_READ,  16'h0000, 8'd0,   8'd2,   5'd24, 1'b0, 8'h00, 1'b0},
    '{OP_DRAW,  16'h0000, 8'd199, 8'd3,   5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_DRAW,  16'hffff, 8'd255, 8'd4,   5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_DRAW,  16'hffff, 8'd7,   8'd150, 5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_DRAW,  16'h8001, 8'd7,   8'd255, 5'd0,  1'b1, 8'h00, 1'b1},
    '{OP_DRAW,  16'h8001, 8'd7,   8'd149, 5'd0,  1'b0, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd149, 5'd0,  1'b0, 8'h00, 1'b0},
    '{OP_NONE,  16'hffff, 8'd255, 8'd255, 5'd31, 1'b1, 8'h00, 1'b0},
    '{OP_CLEAR, 16'h0000, 8'd0,   8'd0,   5'd0,  1'b1, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd0,   5'd0,  1'b1, 8'h00, 1'b0},
    '{OP_READ,  16'h0000, 8'd0,   8'd149, 5'd1,  1'b1, 8'h00, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [15:0] sprite_row;
  logic [7:0]  pixel_x;
  logic [7:0]  line;
  logic [4:0]  byte_column;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_byte;
  logic        clipped;

  logic [7:0] pix_store [STORE_BYTES];
  res_t       want_q [$];

  int unsigned send_idle;
  int unsigned recv_stall;
  int          hold_req;
  int          n_err;
  int          n_checked;
  int          n_draw;
  int          n_draw_clip;
  int          n_read;
  int          n_clear;
  int          n_none;

  sprite_row_blitter_1bpp i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .sprite_row  (sprite_row),
    .pixel_x     (pixel_x),
    .line        (line),
    .byte_column (byte_column),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte),
    .clipped     (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    n_err++;
    if (n_err <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic bit store_masked(input int unsigned row, input int unsigned col,
                                      input logic [7:0] mask, input logic [7:0] bits);
    int unsigned a;
    if (col >= LINE_BYTES) begin
      return 1'b1;
    end
    a = row * LINE_BYTES + col;
    pix_store[a] = (pix_store[a] & ~mask) | (bits & mask);
    return 1'b0;
  endfunction

  function automatic res_t predict_blit(input blit_word_t w);
    res_t        r;
    int unsigned col;
    int unsigned sh;
    logic [23:0] spread;
    logic [7:0]  head_mask;
    r = '0;
    case (w.op)
      OP_DRAW: begin
        if (w.row >= LINE_COUNT) begin
          r.clipped = 1'b1;
        end else begin
          col = 32'(w.x >> 3);
          sh = 32'(w.x & 8'd7);
          spread = {w.spr, 8'h00} >> sh;
          head_mask = 8'hff >> sh;
          r.clipped = store_masked(32'(w.row), col, head_mask, spread[23:16]);
          r.clipped |= store_masked(32'(w.row), col + 1, 8'hff, spread[15:8]);
          if (sh != 0) begin
            r.clipped |= store_masked(32'(w.row), col + 2, ~head_mask, spread[7:0]);
          end
        end
      end
      OP_READ: begin
        if (w.row < LINE_COUNT && w.bcol < LINE_BYTES) begin
          r.read_byte = pix_store[w.row * LINE_BYTES + w.bcol];
        end else begin
          r.clipped = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (pix_store[i]) pix_store[i] = 8'h00;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Starts and ends at a falling edge.
  task automatic push_word(input blit_word_t w, input bit typed, input res_t typed_res);
    res_t r;
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= w.op;
    sprite_row  <= w.spr;
    pixel_x     <= w.x;
    line        <= w.row;
    byte_column <= w.bcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_blit(w);
    want_q.push_back(typed ? typed_res : r);
    case (w.op)
      OP_DRAW: begin
        n_draw++;
        if (r.clipped) n_draw_clip++;
      end
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_none++;
    endcase
    @(negedge clk);
  endtask

  function automatic blit_word_t pick_word();
    blit_word_t  w;
    int unsigned r;
    w.spr = 16'($urandom);
    r = $urandom_range(0, 999);
    if (r < 4 && n_clear < MAX_CLEARS) w.op = OP_CLEAR;
    else if (r < 20) w.op = OP_NONE;
    else if (r < 500) w.op = OP_DRAW;
    else w.op = OP_READ;
    r = $urandom_range(0, 99);
    if (r < 55) w.row = 8'($urandom_range(0, 7));
    else if (r < 65) w.row = 8'(LINE_COUNT - 1 - $urandom_range(0, 3));
    else if (r < 92) w.row = 8'($urandom_range(0, LINE_COUNT - 1));
    else w.row = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 80) w.x = 8'($urandom_range(0, LINE_PIXELS - 1));
    else if (r < 90) w.x = 8'($urandom_range(LINE_PIXELS - 24, LINE_PIXELS - 1));
    else w.x = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 90) w.bcol = 5'($urandom_range(0, LINE_BYTES - 1));
    else w.bcol = 5'($urandom_range(0, 31));
    return w;
  endfunction

  task automatic run_phase(input int words, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    for (int i = 0; i < words; i++) begin
      push_word(pick_word(), 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected (read_byte %02h clipped %0d)",
                                  read_byte, clipped));
      end else begin
        want = want_q.pop_front();
        if (read_byte !== want.read_byte) begin
          report_mismatch($sformatf("result %0d read_byte %02h, expected %02h",
                                    n_checked, read_byte, want.read_byte));
        end
        if (clipped !== want.clipped) begin
          report_mismatch($sformatf("result %0d clipped %0d, expected %0d",
                                    n_checked, clipped, want.clipped));
        end
      end
    end
  end

  initial begin : stimulus
    blit_word_t w;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_DRAW;
    sprite_row  = '0;
    pixel_x     = '0;
    line        = '0;
    byte_column = '0;
    send_idle   = 0;
    recv_stall  = 0;
    hold_req    = 0;
    n_err       = 0;
    n_checked   = 0;
    n_draw      = 0;
    n_draw_clip = 0;
    n_read      = 0;
    n_clear     = 0;
    n_none      = 0;
    foreach (pix_store[i]) pix_store[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      w = '{DIR_TAB[i].op, DIR_TAB[i].spr, DIR_TAB[i].x, DIR_TAB[i].row, DIR_TAB[i].bcol};
      push_word(w, DIR_TAB[i].typed, '{DIR_TAB[i].rd, DIR_TAB[i].clip});
    end

    // The receiver holds off while words keep coming, so the block backs up.
    hold_req++;
    run_phase(PHASE_WORDS, 0, 0);
    run_phase(PHASE_WORDS, 81, 0);
    run_phase(PHASE_WORDS, 0, 81);
    run_phase(PHASE_WORDS, 23, 23);
    in_valid <= 1'b0;

    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d draws (%0d clipped), %0d reads, %0d clears, %0d unused opcodes.",
             n_draw, n_draw_clip, n_read, n_clear, n_none);
    $display("Checked %0d result words over four idling phases and one long hold-off.",
             n_checked);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
